@@ rtl/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types and constants of the two-encoder odometry tracker: item
// structs, controller commands, state codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package odo_pkg;

  // fixed field widths
  localparam int POS_BITS  = 48;
  localparam int HALF_BITS = POS_BITS / 2;
  localparam int DPC_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int IDX_W     = 6;

  // last step index of each phase
  localparam logic [IDX_W-1:0] DIST_LAST   = 6'd2;
  localparam logic [IDX_W-1:0] CORDIC_LAST = 6'd29;
  localparam logic [IDX_W-1:0] ROT_LAST    = 6'd5;
  localparam logic [IDX_W-1:0] SQ_LAST     = 6'd6;
  localparam logic [IDX_W-1:0] ROOT_LAST   = 6'd47;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DPC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DPC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT     = 2'd2;

  localparam logic [15:0] MOUNT_RESET = 16'd57344;

  // CORDIC gain-compensated start value, Q30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // arctangent of 2^-i as a fraction of a 2^32 turn
  localparam logic [31:0] ATAN_TURN [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic        mode;
    logic        wheel;
    logic        dir_level;
    logic [15:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic        [31:0]         step_length;
    logic        [POS_BITS-2:0] radius;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIST,
    OP_CORDIC,
    OP_ROT,
    OP_SQ,
    OP_ROOT,
    OP_PUB
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_CORDIC,
    ST_ROT,
    ST_SQ_STEP,
    ST_ROOT_STEP,
    ST_SQ_RAD,
    ST_ROOT_RAD,
    ST_PUB
  } state_t;

  // command from controller to datapath
  typedef struct packed {
    dp_op_t           op;
    logic             sel;  // 0 step length pair, 1 radius pair
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

@@ rtl/odo_ctrl.sv @@
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer of the tracker: walks a tick through distance scaling, CORDIC,
// rotation, two square sums and two square roots, then hands the result beat
// to the output register.
// ----------------------------------------------------------------------------
module odo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output odo_pkg::cmd_t cmd
);
  import odo_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept, publish;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign publish   = (state_r == ST_PUB) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && in_mode) state_nxt = ST_DIST;
      end
      ST_DIST: if (cnt_r == DIST_LAST) begin
        state_nxt = ST_CORDIC;
        cnt_nxt   = '0;
      end
      ST_CORDIC: if (cnt_r == CORDIC_LAST) begin
        state_nxt = ST_ROT;
        cnt_nxt   = '0;
      end
      ST_ROT: if (cnt_r == ROT_LAST) begin
        state_nxt = ST_SQ_STEP;
        cnt_nxt   = '0;
      end
      ST_SQ_STEP: if (cnt_r == SQ_LAST) begin
        state_nxt = ST_ROOT_STEP;
        cnt_nxt   = '0;
      end
      ST_ROOT_STEP: if (cnt_r == ROOT_LAST) begin
        state_nxt = ST_SQ_RAD;
        cnt_nxt   = '0;
      end
      ST_SQ_RAD: if (cnt_r == SQ_LAST) begin
        state_nxt = ST_ROOT_RAD;
        cnt_nxt   = '0;
      end
      ST_ROOT_RAD: if (cnt_r == ROOT_LAST) begin
        state_nxt = ST_PUB;
        cnt_nxt   = '0;
      end
      ST_PUB: begin
        cnt_nxt = '0;
        if (publish) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // output beat flag: set on publish, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (publish) out_valid_nxt = 1'b1;
  end

  // command outputs
  always_comb begin
    cmd.op  = OP_NONE;
    cmd.sel = 1'b0;
    cmd.idx = cnt_r;
    unique case (state_r)
      ST_IDLE:      if (accept) cmd.op = OP_LOAD;
      ST_DIST:      cmd.op = OP_DIST;
      ST_CORDIC:    cmd.op = OP_CORDIC;
      ST_ROT:       cmd.op = OP_ROT;
      ST_SQ_STEP:   cmd.op = OP_SQ;
      ST_ROOT_STEP: cmd.op = OP_ROOT;
      ST_SQ_RAD: begin
        cmd.op  = OP_SQ;
        cmd.sel = 1'b1;
      end
      ST_ROOT_RAD: begin
        cmd.op  = OP_ROOT;
        cmd.sel = 1'b1;
      end
      ST_PUB:       if (publish) cmd.op = OP_PUB;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/odo_dp.sv @@
// ----------------------------------------------------------------------------
// odo_dp
// Datapath of the tracker: wheel counters, configuration registers, one
// shared registered multiplier, a bit-per-cycle CORDIC, a bit-per-cycle
// square root and the output register.
// ----------------------------------------------------------------------------
module odo_dp #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  odo_pkg::cmd_t                     cmd,
  input  odo_pkg::in_item_t                 in_data,
  input  logic                              cfg_we,
  input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [odo_pkg::CFG_DAT_W-1:0]     cfg_data,
  output odo_pkg::out_item_t                out_data
);
  import odo_pkg::*;

  localparam int REM_W = POS_BITS + 4;
  localparam int SQ_W  = 2 * POS_BITS;

  // configuration
  logic [DPC_W-1:0] rdpc_r, ldpc_r;
  logic [15:0]      mount_r;

  // wheel state
  logic [31:0]        rcnt_r, lcnt_r, rlast_r, llast_r;
  logic signed [15:0] dr_r, dl_r;
  logic signed [39:0] rd_r, ld_r;

  // CORDIC
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic signed [24:0] c_r, s_r;

  // multiplier and accumulators
  logic signed [40:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [65:0] p_r;
  logic signed [65:0] ax_r, ay_r;
  logic [POS_BITS-1:0] x_r, y_r;
  logic [SQ_W-1:0]    sq_r;

  // square root
  logic [REM_W-1:0]    rem_r;
  logic [POS_BITS-1:0] root_r;
  logic [31:0]         step_r;
  logic [POS_BITS-2:0] rad_r;
  out_item_t           out_r;

  assign out_data = out_r;

  // ---- load: angle set-up ----
  logic [31:0]           ang_sum;
  logic [ANGLE_BITS-1:0] theta;
  logic [31:0]           turn;
  logic                  flip0;
  always_comb begin
    ang_sum = 32'(in_data.yaw_angle) + 32'(mount_r);
    theta   = ang_sum[ANGLE_BITS-1:0];
    turn    = {theta, {(32-ANGLE_BITS){1'b0}}};
    flip0   = turn[31] ^ turn[30];
    turn[31] = turn[31] ^ flip0;
  end

  // ---- CORDIC step ----
  logic signed [33:0] xs, ys, at, cx_n, cy_n, cz_n, cv, sv, cr, sr;
  always_comb begin
    xs = cx_r >>> cmd.idx;
    ys = cy_r >>> cmd.idx;
    at = 34'(ATAN_TURN[cmd.idx[4:0]]);
    if (!cz_r[33]) begin
      cx_n = cx_r - ys;
      cy_n = cy_r + xs;
      cz_n = cz_r - at;
    end else begin
      cx_n = cx_r + ys;
      cy_n = cy_r - xs;
      cz_n = cz_r + at;
    end
    cv = flip_r ? -cx_n : cx_n;
    sv = flip_r ? -cy_n : cy_n;
    cr = (cv + 34'sd128) >>> 8;
    sr = (sv + 34'sd128) >>> 8;
  end

  // ---- magnitudes for the square sums ----
  logic [39:0]         mld, mrd;
  logic [POS_BITS-1:0] mx, my, va, vb, vsel;
  logic [HALF_BITS-1:0] vhi, vlo;
  always_comb begin
    mld  = ld_r[39] ? 40'(-ld_r) : 40'(ld_r);
    mrd  = rd_r[39] ? 40'(-rd_r) : 40'(rd_r);
    mx   = x_r[POS_BITS-1] ? (~x_r + 1'b1) : x_r;
    my   = y_r[POS_BITS-1] ? (~y_r + 1'b1) : y_r;
    va   = cmd.sel ? mx : POS_BITS'(mld);
    vb   = cmd.sel ? my : POS_BITS'(mrd);
    vsel = (cmd.idx < 6'd3) ? va : vb;
    vhi  = vsel[POS_BITS-1:HALF_BITS];
    vlo  = vsel[HALF_BITS-1:0];
  end

  // ---- multiplier operand selection ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_DIST: begin
        if (cmd.idx == 6'd0) begin
          mul_a = 41'(dr_r);
          mul_b = {1'b0, rdpc_r};
        end else begin
          mul_a = 41'(dl_r);
          mul_b = {1'b0, ldpc_r};
        end
      end
      OP_ROT: begin
        unique case (cmd.idx[1:0])
          2'd0: begin mul_a = 41'(ld_r); mul_b = c_r; end
          2'd1: begin mul_a = 41'(rd_r); mul_b = s_r; end
          2'd2: begin mul_a = 41'(ld_r); mul_b = s_r; end
          default: begin mul_a = 41'(rd_r); mul_b = c_r; end
        endcase
      end
      OP_SQ: begin
        unique case (cmd.idx)
          6'd0, 6'd3: begin
            mul_a = {17'b0, vhi};
            mul_b = {1'b0, vhi};
          end
          6'd1, 6'd4: begin
            mul_a = {17'b0, vhi};
            mul_b = {1'b0, vlo};
          end
          default: begin
            mul_a = {17'b0, vlo};
            mul_b = {1'b0, vlo};
          end
        endcase
      end
      default: ;
    endcase
  end

  // ---- accumulation terms ----
  logic [IDX_W-1:0]   kd;
  logic [SQ_W-1:0]    sq_term;
  logic signed [65:0] rx, ry;
  logic [POS_BITS-1:0] dx, dy;
  always_comb begin
    kd = cmd.idx - 1'b1;
    unique case (kd)
      6'd0, 6'd3: sq_term = SQ_W'(p_r[SQ_W/2-1:0]) << (2 * HALF_BITS);
      6'd1, 6'd4: sq_term = SQ_W'(p_r[SQ_W/2-1:0]) << (HALF_BITS + 1);
      default:    sq_term = SQ_W'(p_r[SQ_W/2-1:0]);
    endcase
    rx = ax_r + 66'sd2097152;
    ry = ay_r + 66'sd2097152;
    dx = POS_BITS'(rx >>> 22);
    dy = POS_BITS'(ry >>> 22);
  end

  // ---- square root step ----
  logic [REM_W-1:0]    rem_t, trial, rem_n;
  logic                ge;
  logic [POS_BITS-1:0] root_n;
  always_comb begin
    rem_t  = {rem_r[REM_W-3:0], sq_r[SQ_W-1:SQ_W-2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = (rem_t >= trial);
    rem_n  = ge ? (rem_t - trial) : rem_t;
    root_n = {root_r[POS_BITS-2:0], ge};
  end

  // ---- configuration and persistent state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdpc_r  <= '0;
      ldpc_r  <= '0;
      mount_r <= MOUNT_RESET;
      rcnt_r  <= '0;
      lcnt_r  <= '0;
      rlast_r <= '0;
      llast_r <= '0;
      x_r     <= '0;
      y_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RIGHT_DPC: rdpc_r  <= cfg_data;
          REG_LEFT_DPC:  ldpc_r  <= cfg_data;
          REG_MOUNT:     mount_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        if (!in_data.mode) begin
          if (in_data.wheel) lcnt_r <= in_data.dir_level ? lcnt_r + 1'b1 : lcnt_r - 1'b1;
          else               rcnt_r <= in_data.dir_level ? rcnt_r + 1'b1 : rcnt_r - 1'b1;
        end else begin
          rlast_r <= rcnt_r;
          llast_r <= lcnt_r;
        end
      end
      // position update once both rotated sums are complete
      if (cmd.op == OP_ROT && cmd.idx == ROT_LAST) begin
        x_r <= x_r + dx;
        y_r <= y_r + dy;
      end
    end
  end

  // ---- working registers ----
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    unique case (cmd.op)
      OP_LOAD: begin
        dr_r   <= $signed(rcnt_r[15:0] - rlast_r[15:0]);
        dl_r   <= $signed(lcnt_r[15:0] - llast_r[15:0]);
        flip_r <= flip0;
        cx_r   <= CORDIC_X0;
        cy_r   <= '0;
        cz_r   <= 34'($signed(turn));
      end
      OP_DIST: begin
        if (cmd.idx == 6'd1) rd_r <= p_r[39:0];
        if (cmd.idx == 6'd2) ld_r <= p_r[39:0];
      end
      OP_CORDIC: begin
        cx_r <= cx_n;
        cy_r <= cy_n;
        cz_r <= cz_n;
        if (cmd.idx == CORDIC_LAST) begin
          c_r <= cr[24:0];
          s_r <= sr[24:0];
        end
      end
      OP_ROT: begin
        unique case (cmd.idx)
          6'd0: begin ax_r <= '0; ay_r <= '0; end
          6'd1: ax_r <= ax_r + p_r;
          6'd2: ax_r <= ax_r - p_r;
          6'd3, 6'd4: ay_r <= ay_r + p_r;
          default: ;
        endcase
      end
      OP_SQ: begin
        if (cmd.idx == 6'd0) begin
          sq_r   <= '0;
          rem_r  <= '0;
          root_r <= '0;
        end else begin
          sq_r <= sq_r + sq_term;
        end
      end
      OP_ROOT: begin
        rem_r  <= rem_n;
        root_r <= root_n;
        sq_r   <= {sq_r[SQ_W-3:0], 2'b00};
        if (cmd.idx == ROOT_LAST) begin
          if (!cmd.sel) begin
            step_r <= (root_n[POS_BITS-1:32] != '0) ? '1 : root_n[31:0];
          end else begin
            rad_r <= root_n[POS_BITS-1] ? '1 : root_n[POS_BITS-2:0];
          end
        end
      end
      // output register only changes when a new beat is handed over
      OP_PUB: begin
        out_r.pos_x       <= x_r;
        out_r.pos_y       <= y_r;
        out_r.step_length <= step_r;
        out_r.radius      <= rad_r;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/two_encoder_odometry_tracker.sv @@
// ----------------------------------------------------------------------------
// two_encoder_odometry_tracker
// Dead-reckoning tracker: two wheel encoders plus gyro heading give a
// fixed-point X/Y position, step length and radius per sample tick.
// ----------------------------------------------------------------------------
// An encoder edge beat gives no result. A sample tick beat goes through load,
// the two distance products, the CORDIC sine/cosine (one iteration a cycle),
// the four rotation products on the single shared multiplier, and twice a
// sum of squares followed by a one-bit-per-cycle square root, before the
// result beat is handed over. Input is stalled while a tick is worked on; the
// result sits in its own output register, so further edge beats are taken
// while it waits. Configuration writes are always ready and must only be
// made while idle.
module two_encoder_odometry_tracker #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  odo_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output odo_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [odo_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import odo_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  odo_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

@@ dv/odometry_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_checker
// Watches the input, result and register channels of the odometry tracker,
// keeps its own copy of the counters, registers and position, works out the
// result of every sample tick and compares each result beat against it.
// ----------------------------------------------------------------------------
module odometry_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  odo_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  odo_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import odo_pkg::*;

  // predictor state
  logic [23:0] right_dpc, left_dpc;
  logic [15:0] mount;
  logic [31:0] right_cnt, left_cnt, right_prev, left_prev;
  logic [POS_BITS-1:0] x_pos, y_pos;

  out_item_t expected_results[$];

  // floor(sqrt(a^2 + b^2)), exact over 128 bits
  function automatic logic [63:0] root_of_squares(logic [63:0] a, logic [63:0] b);
    logic [127:0] n, sq;
    logic [63:0] r, cand;
    n = {64'd0, a} * {64'd0, a} + {64'd0, b} * {64'd0, b};
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      cand = r | (64'd1 << bit_i);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // CORDIC sine/cosine of a 32-bit turn fraction, rounded to Q22
  task automatic heading_sincos(input logic [31:0] turn, output longint c, output longint s);
    longint x, y, z, xs, ys;
    logic flip;
    logic [31:0] t;
    t = turn;
    flip = (t - 32'h4000_0000) < 32'h8000_0000;
    if (flip) t = t - 32'h8000_0000;
    z = longint'($signed(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TURN[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TURN[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = (x + 128) >>> 8;
    s = (y + 128) >>> 8;
  endtask

  // one tick: deltas, distances, rotation, accumulate, lengths
  task automatic predict_tick(input logic [15:0] yaw);
    logic [15:0] ur, ul, th;
    shortint dr, dl;
    longint rd, ld, c, s, dx, dy, px, py;
    logic [63:0] step, rad;
    out_item_t res;
    ur = 16'(right_cnt - right_prev);
    ul = 16'(left_cnt - left_prev);
    dr = $signed(ur);
    dl = $signed(ul);
    right_prev = right_cnt;
    left_prev  = left_cnt;
    rd = longint'(dr) * longint'({40'd0, right_dpc});
    ld = longint'(dl) * longint'({40'd0, left_dpc});
    th = yaw + mount;
    heading_sincos({th, 16'd0}, c, s);
    dx = (ld * c - rd * s + (64'sd1 <<< 21)) >>> 22;
    dy = (ld * s + rd * c + (64'sd1 <<< 21)) >>> 22;
    x_pos = x_pos + dx[POS_BITS-1:0];
    y_pos = y_pos + dy[POS_BITS-1:0];
    step = root_of_squares(magnitude(ld), magnitude(rd));
    if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
    px = longint'($signed(x_pos));
    py = longint'($signed(y_pos));
    rad = root_of_squares(magnitude(px), magnitude(py));
    if (rad > {17'd0, {(POS_BITS-1){1'b1}}}) rad = {17'd0, {(POS_BITS-1){1'b1}}};
    res.pos_x       = x_pos;
    res.pos_y       = y_pos;
    res.step_length = step[31:0];
    res.radius      = rad[POS_BITS-2:0];
    expected_results.push_back(res);
  endtask

  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst_n) begin
      right_dpc = '0; left_dpc = '0; mount = MOUNT_RESET;
      right_cnt = '0; left_cnt = '0; right_prev = '0; left_prev = '0;
      x_pos = '0; y_pos = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.pos_x !== exp_res.pos_x) begin
            $error("pos_x exp %0d got %0d", exp_res.pos_x, out_data.pos_x);
            fail_count++;
          end
          if (out_data.pos_y !== exp_res.pos_y) begin
            $error("pos_y exp %0d got %0d", exp_res.pos_y, out_data.pos_y);
            fail_count++;
          end
          if (out_data.step_length !== exp_res.step_length) begin
            $error("step_length exp %0d got %0d", exp_res.step_length,
                   out_data.step_length);
            fail_count++;
          end
          if (out_data.radius !== exp_res.radius) begin
            $error("radius exp %0d got %0d", exp_res.radius, out_data.radius);
            fail_count++;
          end
        end
      end
      // input beat
      if (in_valid && !in_stall) begin
        if (in_data.mode) begin
          predict_tick(in_data.yaw_angle);
        end else if (in_data.wheel) begin
          left_cnt = in_data.dir_level ? left_cnt + 1 : left_cnt - 1;
        end else begin
          right_cnt = in_data.dir_level ? right_cnt + 1 : right_cnt - 1;
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RIGHT_DPC: right_dpc = cfg_data;
          REG_LEFT_DPC:  left_dpc  = cfg_data;
          REG_MOUNT:     mount     = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ dv/two_encoder_odometry_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_encoder_odometry_tracker_tb
// Drives encoder edges and sample ticks through several register settings,
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module two_encoder_odometry_tracker_tb;
  import odo_pkg::*;

  localparam int SETTLE    = 200;
  localparam int MAX_CYCLE = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  logic quiet = 1'b0;
  logic jitter = 1'b1;
  int stall_left = 0;

  always #5 clk = ~clk;

  two_encoder_odometry_tracker dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  odometry_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("two_encoder_odometry_tracker_tb NOT OK");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one input beat, then maybe an idle burst
  task automatic send_beat(input in_item_t item);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && jitter && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_edge(input logic wheel, input logic up);
    send_beat('{mode: 1'b0, wheel: wheel, dir_level: up, yaw_angle: 16'($urandom)});
  endtask

  task automatic send_tick(input logic [15:0] yaw);
    send_beat('{mode: 1'b1, wheel: 1'($urandom), dir_level: 1'($urandom),
                yaw_angle: yaw});
  endtask

  // wait for all results and the tail of the last beat
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random traffic: runs of edges with a drift, ticks in between
  task automatic random_phase(input int n_items);
    logic up_r, up_l;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        up_r = 1'($urandom);
        up_l = 1'($urandom);
      end
      if ($urandom_range(0, 5) == 0) begin
        send_tick(16'($urandom));
      end else if ($urandom_range(0, 1)) begin
        send_edge(1'b0, ($urandom_range(0, 4) == 0) ? !up_r : up_r);
      end else begin
        send_edge(1'b1, ($urandom_range(0, 4) == 0) ? !up_l : up_l);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, zero motion, then extremes
    send_tick(16'h0000);
    send_edge(1'b0, 1'b0);
    send_edge(1'b1, 1'b0);
    send_tick(16'hFFFF);
    drain();
    write_reg(REG_RIGHT_DPC, 24'hFFFFFF);
    write_reg(REG_LEFT_DPC, 24'hFFFFFF);
    write_reg(REG_MOUNT, 24'h0);
    write_reg(2'd3, 24'h123456);
    send_edge(1'b0, 1'b1);
    send_edge(1'b1, 1'b1);
    send_tick(16'h4000);
    send_edge(1'b0, 1'b1);
    send_tick(16'h8000);
    send_edge(1'b1, 1'b0);
    send_tick(16'hC000);
    send_tick(16'h3FFF);
    send_tick(16'hBFFF);

    // long one-way runs between two ticks, back to back
    jitter = 1'b0;
    repeat (300) send_edge(1'b0, 1'b1);
    repeat (300) send_edge(1'b1, 1'b0);
    jitter = 1'b1;
    send_tick(16'h1234);
    send_tick(16'h7FFF);

    // sender holds off until every result is back
    drain();
    write_reg(REG_MOUNT, 24'hFFFF);
    random_phase(400);
    drain();
    write_reg(REG_RIGHT_DPC, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_LEFT_DPC, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_MOUNT, 24'($urandom_range(0, 16'hFFFF)));
    random_phase(400);
    drain();
    write_reg(REG_RIGHT_DPC, 24'd65536);
    write_reg(REG_LEFT_DPC, 24'd205887);
    write_reg(REG_MOUNT, 24'(MOUNT_RESET));
    random_phase(400);
    drain();
    write_reg(REG_RIGHT_DPC, 24'($urandom));
    write_reg(REG_LEFT_DPC, 24'($urandom));
    write_reg(REG_MOUNT, 24'($urandom));
    quiet = 1'b1;
    random_phase(400);
    drain();

    if (fail_count == 0) begin
      $display("two_encoder_odometry_tracker_tb OK");
    end else begin
      $display("two_encoder_odometry_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
